[design/stq_pkg.sv]
// Shared constants and types for the sorted timer queue.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

  localparam int NumSlots   = 16;
  localparam int SlotW      = $clog2(NumSlots);
  localparam int TimeW      = 48;
  localparam int MaxResults = 16;
  localparam int CntW       = $clog2(MaxResults + 1);

  localparam int ModeW      = 2;
  localparam int SlotFieldW = 4;

  // Input tdata: timer_slot, due_time, interval, padded to whole bytes.
  localparam int InFieldsW  = SlotFieldW + 2 * TimeW;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  // Output tdata: fired_slot, fired_due, padded to whole bytes.
  localparam int OutFieldsW = SlotFieldW + TimeW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [ModeW-1:0] ModeTick   = 2'd0;
  localparam logic [ModeW-1:0] ModeArm    = 2'd1;
  localparam logic [ModeW-1:0] ModeDisarm = 2'd2;

  // Write request into the slot store.
  typedef struct packed {
    logic             due_en;
    logic             ivl_en;
    logic             armed_en;
    logic             armed_val;
    logic [SlotW-1:0] idx;
    logic [TimeW-1:0] due;
    logic [TimeW-1:0] ivl;
  } slot_wr_t;

  // Contents of one slot as read from the store.
  typedef struct packed {
    logic             armed;
    logic [TimeW-1:0] due;
    logic [TimeW-1:0] ivl;
  } slot_rd_t;

endpackage
`default_nettype wire

[design/stq_slot_store.sv]
// Slot store: due time, interval and armed bit for every timer slot.
`timescale 1ns / 1ps
`default_nettype none
module stq_slot_store (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire stq_pkg::slot_wr_t       wr_i,
  input  wire logic [stq_pkg::SlotW-1:0] rd_idx_i,
  output stq_pkg::slot_rd_t            rd_o
);

  logic [stq_pkg::TimeW-1:0]    due_q [stq_pkg::NumSlots];
  logic [stq_pkg::TimeW-1:0]    ivl_q [stq_pkg::NumSlots];
  logic [stq_pkg::NumSlots-1:0] armed_q;

  // Due time and interval of a slot are only looked at while it is armed,
  // and arming always writes both, so they carry no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.due_en) begin
      due_q[wr_i.idx] <= wr_i.due;
    end
    if (wr_i.ivl_en) begin
      ivl_q[wr_i.idx] <= wr_i.ivl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else if (wr_i.armed_en) begin
      armed_q[wr_i.idx] <= wr_i.armed_val;
    end
  end

  assign rd_o.armed = armed_q[rd_idx_i];
  assign rd_o.due   = due_q[rd_idx_i];
  assign rd_o.ivl   = ivl_q[rd_idx_i];

endmodule
`default_nettype wire

[design/sorted_timer_queue.sv]
// Top level of the sorted timer queue: request sequencer, slot scan and result register.
//
//  channel  | direction | handshake               | contents
//  s_axis   | in        | tvalid/tready           | tuser: mode; tdata: slot, due, interval
//  m_axis   | out       | tvalid/tready, tlast    | tuser: fire flag; tdata: slot, fired due
//
// After the accepting edge tready stays low through the floor, write and acknowledge
// states on an arm and the acknowledge state on a disarm, the last of them loading the
// acknowledge. A tick holds it low for one pass over the NumSlots slots of the store per
// fired slot plus one final pass, none after MaxResults fired slots, with decide, emit
// and fire states between passes, given the single read port and the one shared comparator.
// A request is taken only while the sequencer is idle; a stalled result holds the
// sequencer. Reset clears the time counter, all armed bits and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_queue (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: [3:0] timer_slot, [51:4] due_time, [99:52] interval, rest zero
  input  wire logic [stq_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: [1:0] mode
  input  wire logic [stq_pkg::ModeW-1:0]    s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // tdata: [3:0] fired_slot, [51:4] fired_due, rest zero
  output logic [stq_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // tuser: [0] fire_valid
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);

  localparam int TimeW = stq_pkg::TimeW;
  localparam int SlotW = stq_pkg::SlotW;
  localparam int SfW   = stq_pkg::SlotFieldW;
  localparam int CntW  = stq_pkg::CntW;

  typedef enum logic [2:0] {
    StIdle,
    StArmFloor,
    StArmWrite,
    StAck,
    StScan,
    StDecide,
    StEmit,
    StFire
  } state_e;

  state_e                  state_q;
  logic [SfW-1:0]          lat_slot_q;
  logic [TimeW-1:0]        lat_due_q;
  logic [TimeW-1:0]        lat_ivl_q;
  logic [TimeW-1:0]        floor_q;
  logic [TimeW-1:0]        now_q;
  logic [SlotW-1:0]        scan_idx_q;
  logic                    first_q;
  logic [stq_pkg::NumSlots-1:0] ready_q;
  logic                    best_v_q;
  logic [SlotW-1:0]        best_idx_q;
  logic [TimeW-1:0]        best_due_q;
  logic                    have_pend_q;
  logic [SlotW-1:0]        pend_slot_q;
  logic [TimeW-1:0]        pend_due_q;
  logic                    emit_last_q;
  logic [CntW-1:0]         fire_cnt_q;
  logic                    out_v_q;
  logic                    out_user_q;
  logic [SfW-1:0]          out_slot_q;
  logic [TimeW-1:0]        out_due_q;
  logic                    out_last_q;

  stq_pkg::slot_wr_t       wr;
  stq_pkg::slot_rd_t       rd;
  logic [SlotW-1:0]        rd_idx;

  logic                    in_accept;
  logic [stq_pkg::ModeW-1:0] in_mode;
  logic [SfW-1:0]          in_slot;
  logic [TimeW-1:0]        in_due;
  logic [TimeW-1:0]        in_ivl;
  logic                    in_slot_ok;
  logic                    lat_slot_ok;
  logic                    out_free;
  logic                    out_load;
  logic                    cand;
  logic                    better;
  logic                    scan_end;
  logic [TimeW:0]          rearm_sum;
  logic [TimeW-1:0]        rearm_due;

  assign in_mode = s_axis_tuser_i;
  assign in_slot = s_axis_tdata_i[SfW-1:0];
  assign in_due  = s_axis_tdata_i[SfW+TimeW-1:SfW];
  assign in_ivl  = s_axis_tdata_i[SfW+2*TimeW-1:SfW+TimeW];

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign in_slot_ok  = (32'(in_slot) < stq_pkg::NumSlots);
  assign lat_slot_ok = (32'(lat_slot_q) < stq_pkg::NumSlots);

  assign out_free = !out_v_q || m_axis_tready_i;
  // A new result is loaded into the output register this cycle.
  assign out_load = out_free && ((state_q == StAck) || (state_q == StEmit));

  // The fire cycle reads the chosen slot; every other cycle reads the scan slot.
  assign rd_idx = (state_q == StFire) ? best_idx_q : scan_idx_q;

  // The first pass of a tick decides which slots are due; later passes only
  // consider slots still marked due and not yet fired.
  assign cand     = first_q ? (rd.armed && (rd.due <= now_q)) : ready_q[scan_idx_q];
  assign better   = cand && (!best_v_q || (rd.due > best_due_q));
  assign scan_end = (scan_idx_q == SlotW'(stq_pkg::NumSlots - 1));

  // Rearm saturates at the largest time value when the sum carries out.
  assign rearm_sum = {1'b0, best_due_q} + {1'b0, rd.ivl};
  assign rearm_due = rearm_sum[TimeW] ? '1 : rearm_sum[TimeW-1:0];

  always_comb begin
    wr = '0;
    unique case (state_q)
      StIdle: begin
        if (in_accept && (in_mode == stq_pkg::ModeDisarm) && in_slot_ok) begin
          wr.armed_en  = 1'b1;
          wr.armed_val = 1'b0;
          wr.idx       = SlotW'(in_slot);
        end
      end
      StArmWrite: begin
        if (lat_slot_ok) begin
          wr.due_en    = 1'b1;
          wr.ivl_en    = 1'b1;
          wr.armed_en  = 1'b1;
          wr.armed_val = 1'b1;
          wr.idx       = SlotW'(lat_slot_q);
          wr.due       = (lat_due_q > floor_q) ? lat_due_q : floor_q;
          wr.ivl       = lat_ivl_q;
        end
      end
      StFire: begin
        wr.idx = best_idx_q;
        if (rd.ivl != '0) begin
          wr.due_en = 1'b1;
          wr.due    = rearm_due;
        end else begin
          wr.armed_en  = 1'b1;
          wr.armed_val = 1'b0;
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  stq_slot_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_idx_i (rd_idx),
    .rd_o     (rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      lat_slot_q  <= '0;
      lat_due_q   <= '0;
      lat_ivl_q   <= '0;
      floor_q     <= '0;
      now_q       <= '0;
      scan_idx_q  <= '0;
      first_q     <= 1'b0;
      ready_q     <= '0;
      best_v_q    <= 1'b0;
      best_idx_q  <= '0;
      best_due_q  <= '0;
      have_pend_q <= 1'b0;
      pend_slot_q <= '0;
      pend_due_q  <= '0;
      emit_last_q <= 1'b0;
      fire_cnt_q  <= '0;
      out_v_q     <= 1'b0;
      out_user_q  <= 1'b0;
      out_slot_q  <= '0;
      out_due_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_v_q && m_axis_tready_i && !out_load) begin
        out_v_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_accept) begin
            lat_slot_q <= in_slot;
            lat_due_q  <= in_due;
            lat_ivl_q  <= in_ivl;
            priority if (in_mode == stq_pkg::ModeArm) begin
              state_q <= StArmFloor;
            end else if (in_mode == stq_pkg::ModeDisarm) begin
              state_q <= StAck;
            end else if (in_mode == stq_pkg::ModeTick) begin
              now_q       <= now_q + 1'b1;
              scan_idx_q  <= '0;
              first_q     <= 1'b1;
              best_v_q    <= 1'b0;
              have_pend_q <= 1'b0;
              fire_cnt_q  <= '0;
              state_q     <= StScan;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        StArmFloor: begin
          floor_q <= (lat_ivl_q > now_q) ? '0 : (now_q - lat_ivl_q);
          state_q <= StArmWrite;
        end
        StArmWrite: begin
          state_q <= StAck;
        end
        StAck: begin
          if (out_free) begin
            out_v_q    <= 1'b1;
            out_user_q <= 1'b0;
            out_slot_q <= lat_slot_q;
            out_due_q  <= '0;
            out_last_q <= 1'b1;
            state_q    <= StIdle;
          end
        end
        StScan: begin
          if (first_q) begin
            ready_q[scan_idx_q] <= cand;
          end
          if (better) begin
            best_v_q   <= 1'b1;
            best_idx_q <= scan_idx_q;
            best_due_q <= rd.due;
          end
          scan_idx_q <= scan_idx_q + 1'b1;
          if (scan_end) begin
            state_q <= StDecide;
          end
        end
        StDecide: begin
          // A held result is last only when this pass found nothing more.
          if (best_v_q) begin
            if (have_pend_q) begin
              emit_last_q <= 1'b0;
              state_q     <= StEmit;
            end else begin
              state_q <= StFire;
            end
          end else if (have_pend_q) begin
            emit_last_q <= 1'b1;
            state_q     <= StEmit;
          end else begin
            state_q <= StIdle;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_v_q     <= 1'b1;
            out_user_q  <= 1'b1;
            out_slot_q  <= SfW'(pend_slot_q);
            out_due_q   <= pend_due_q;
            out_last_q  <= emit_last_q;
            have_pend_q <= 1'b0;
            state_q     <= emit_last_q ? StIdle : StFire;
          end
        end
        StFire: begin
          pend_slot_q         <= best_idx_q;
          pend_due_q          <= best_due_q;
          have_pend_q         <= 1'b1;
          ready_q[best_idx_q] <= 1'b0;
          fire_cnt_q          <= fire_cnt_q + 1'b1;
          if (fire_cnt_q == CntW'(stq_pkg::MaxResults - 1)) begin
            emit_last_q <= 1'b1;
            state_q     <= StEmit;
          end else begin
            scan_idx_q <= '0;
            first_q    <= 1'b0;
            best_v_q   <= 1'b0;
            state_q    <= StScan;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(stq_pkg::OutDataW - stq_pkg::OutFieldsW){1'b0}},
                            out_due_q, out_slot_q};

endmodule
`default_nettype wire

[bench/tb_sorted_timer_queue.sv]
// Self-checking testbench for the sorted timer queue with a slot-level predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_timer_queue;

  localparam int ModeW      = stq_pkg::ModeW;
  localparam int SlotFieldW = stq_pkg::SlotFieldW;
  localparam int TimeW      = stq_pkg::TimeW;
  localparam int NumSlots   = stq_pkg::NumSlots;
  localparam int MaxResults = stq_pkg::MaxResults;
  localparam int InDataW    = stq_pkg::InDataW;
  localparam int InFieldsW  = stq_pkg::InFieldsW;
  localparam int OutDataW   = stq_pkg::OutDataW;
  localparam logic [ModeW-1:0] ModeTick   = stq_pkg::ModeTick;
  localparam logic [ModeW-1:0] ModeArm    = stq_pkg::ModeArm;
  localparam logic [ModeW-1:0] ModeDisarm = stq_pkg::ModeDisarm;

  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam logic [TimeW-1:0] TimeMax    = {TimeW{1'b1}};
  localparam int RandomReqs  = 255;
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 100;
  localparam int HoldCycles  = 400;
  localparam int HoldAfter   = 120;
  localparam int CalmTail    = 30;

  typedef struct packed {
    logic [ModeW-1:0]      mode;
    logic [SlotFieldW-1:0] slot;
    logic [TimeW-1:0]      due;
    logic [TimeW-1:0]      ivl;
  } timer_req_t;

  typedef struct packed {
    logic                  fire;
    logic [SlotFieldW-1:0] slot;
    logic [TimeW-1:0]      due;
    logic                  last;
  } timer_res_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [InDataW-1:0]    s_tdata = '0;
  logic [ModeW-1:0]      s_tuser = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OutDataW-1:0]   m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  timer_req_t pending_reqs[$];
  timer_res_t due_reports[$];
  timer_req_t req_on_bus;

  // Predictor state.
  logic [TimeW-1:0] model_now;
  logic [TimeW-1:0] model_due[NumSlots];
  logic [TimeW-1:0] model_ivl[NumSlots];
  logic             model_armed[NumSlots];

  int mismatches   = 0;
  int accepted_cnt = 0;
  int src_gap      = 0;
  int sink_stall   = 0;
  int hold_cnt     = 0;
  bit hold_done    = 1'b0;
  int cycle_cnt    = 0;
  int gen_now      = 0;

  sorted_timer_queue i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [TimeW-1:0] rand_time();
    logic [63:0] r;
    begin
      r = {$urandom, $urandom};
      return r[TimeW-1:0];
    end
  endfunction

  task automatic queue_req(input logic [ModeW-1:0] mode, input int slot,
                           input logic [TimeW-1:0] due, input logic [TimeW-1:0] ivl);
    timer_req_t rq;
    begin
      rq.mode = mode;
      rq.slot = slot[SlotFieldW-1:0];
      rq.due  = due;
      rq.ivl  = ivl;
      pending_reqs.push_back(rq);
    end
  endtask

  // Applies one accepted request to the slot model and queues the results it causes.
  task automatic apply_request(input timer_req_t rq);
    logic [TimeW-1:0] floor_t;
    logic [TimeW-1:0] fired;
    logic             ready[NumSlots];
    int               picks[MaxResults];
    logic [TimeW-1:0] fired_at[MaxResults];
    int               pick;
    int               count;
    bit               found;
    timer_res_t       res;
    begin
      if (rq.mode == ModeArm || rq.mode == ModeDisarm) begin
        if (int'(rq.slot) < NumSlots) begin
          if (rq.mode == ModeArm) begin
            // A late timer is pulled up to now - interval so it cannot flood.
            floor_t = (rq.ivl > model_now) ? '0 : model_now - rq.ivl;
            model_due[rq.slot]   = (rq.due > floor_t) ? rq.due : floor_t;
            model_ivl[rq.slot]   = rq.ivl;
            model_armed[rq.slot] = 1'b1;
          end else begin
            model_armed[rq.slot] = 1'b0;
          end
        end
        res = '{fire: 1'b0, slot: rq.slot, due: '0, last: 1'b1};
        due_reports.push_back(res);
      end else if (rq.mode == ModeTick) begin
        model_now = model_now + 1'b1;
        for (int i = 0; i < NumSlots; i++) begin
          ready[i] = model_armed[i] && (model_due[i] <= model_now);
        end
        count = 0;
        found = 1'b1;
        while (count < MaxResults && found) begin
          pick  = 0;
          found = 1'b0;
          for (int i = 0; i < NumSlots; i++) begin
            if (ready[i] && (!found || model_due[i] > model_due[pick])) begin
              pick  = i;
              found = 1'b1;
            end
          end
          if (found) begin
            ready[pick] = 1'b0;
            fired = model_due[pick];
            if (model_ivl[pick] != '0) begin
              model_due[pick] = (model_ivl[pick] > (TimeMax - fired)) ?
                                TimeMax : fired + model_ivl[pick];
            end else begin
              model_armed[pick] = 1'b0;
            end
            picks[count]    = pick;
            fired_at[count] = fired;
            count++;
          end
        end
        for (int k = 0; k < count; k++) begin
          res.fire = 1'b1;
          res.slot = picks[k][SlotFieldW-1:0];
          res.due  = fired_at[k];
          res.last = (k == count - 1);
          due_reports.push_back(res);
        end
      end
    end
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      src_gap <= 0;
    end else begin
      if (s_valid && s_ready) begin
        apply_request(req_on_bus);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_valid || s_ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req_on_bus = pending_reqs[0];
          pending_reqs.delete(0);
          s_tdata <= {{(InDataW-InFieldsW){1'b0}}, req_on_bus.ivl, req_on_bus.due,
                      req_on_bus.slot};
          s_tuser <= req_on_bus.mode;
          s_valid <= 1'b1;
          if (pending_reqs.size() > CalmTail && $urandom_range(0, 4) == 0) begin
            src_gap <= $urandom_range(1, 10);
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && accepted_cnt >= HoldAfter) begin
      hold_cnt  <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // Result receiver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      sink_stall <= 0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      m_ready    <= 1'b0;
    end else if (pending_reqs.size() > CalmTail && $urandom_range(0, 7) == 0) begin
      sink_stall <= $urandom_range(0, 9);
      m_ready    <= 1'b0;
    end else begin
      m_ready <= (hold_cnt == 0);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    timer_res_t seen;
    timer_res_t want;
    if (rst_ni && m_valid && m_ready) begin
      seen.fire = m_tuser;
      seen.slot = m_tdata[SlotFieldW-1:0];
      seen.due  = m_tdata[SlotFieldW +: TimeW];
      seen.last = m_tlast;
      if (due_reports.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: fire=%0b slot=%0d due=%0d last=%0b",
                   seen.fire, seen.slot, seen.due, seen.last);
        end
        mismatches++;
      end else begin
        want = due_reports[0];
        due_reports.delete(0);
        if (seen != want) begin
          if (mismatches < 10) begin
            $display("result mismatch: want fire=%0b slot=%0d due=%0d last=%0b",
                     want.fire, want.slot, want.due, want.last);
            $display("                 got  fire=%0b slot=%0d due=%0d last=%0b",
                     seen.fire, seen.slot, seen.due, seen.last);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int gen_cnt;
    int pick;
    int slot;
    int r;
    logic [TimeW-1:0] due;
    logic [TimeW-1:0] ivl;

    model_now = '0;
    for (int i = 0; i < NumSlots; i++) begin
      model_due[i]   = '0;
      model_ivl[i]   = '0;
      model_armed[i] = 1'b0;
    end

    // Directed part: unused mode, quiet tick, all slots due at once with ties,
    // one-shot, recurring, saturating rearm, late arm floor, overwrite and disarms.
    queue_req(ModeUnused, 3, rand_time(), rand_time());
    queue_req(ModeTick, 0, '0, '0);
    gen_now = 1;
    for (int i = 0; i < NumSlots; i++) begin
      case (i % 4)
        0: ivl = '0;
        1: ivl = TimeW'(1);
        2: ivl = TimeMax;
        default: ivl = TimeW'(5);
      endcase
      queue_req(ModeArm, i, TimeW'(i % 3), ivl);
    end
    queue_req(ModeTick, 0, '0, '0);
    gen_now = 2;
    queue_req(ModeArm, 5, TimeMax, '0);
    queue_req(ModeDisarm, 5, '0, '0);
    queue_req(ModeDisarm, 9, TimeMax, TimeMax);
    queue_req(ModeUnused, 0, '0, '0);
    queue_req(ModeTick, 15, TimeMax, TimeMax);
    queue_req(ModeTick, 0, '0, '0);
    gen_now = 4;

    // Random part: mostly arms close to the current time and ticks.
    gen_cnt = 0;
    while (gen_cnt < RandomReqs) begin
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, NumSlots - 1);
      r    = $urandom_range(0, 9);
      if (r < 4) begin
        ivl = '0;
      end else if (r < 8) begin
        ivl = TimeW'($urandom_range(1, 4));
      end else if (r < 9) begin
        ivl = TimeW'($urandom_range(5, 40));
      end else begin
        ivl = rand_time();
      end
      if (pick < 42) begin
        queue_req(ModeTick, slot, rand_time(), rand_time());
        gen_now++;
      end else if (pick < 70) begin
        due = TimeW'(gen_now + int'($urandom_range(0, 6)));
        queue_req(ModeArm, slot, due, ivl);
      end else if (pick < 78) begin
        due = TimeW'($urandom_range(0, gen_now));
        queue_req(ModeArm, slot, due, TimeW'($urandom_range(0, 3)));
      end else if (pick < 84) begin
        queue_req(ModeArm, slot, rand_time(), rand_time());
      end else if (pick < 97) begin
        queue_req(ModeDisarm, slot, rand_time(), rand_time());
      end else begin
        queue_req(ModeUnused, slot, rand_time(), rand_time());
        gen_cnt--;
      end
      gen_cnt++;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || s_valid) @(negedge clk_i);
    while (due_reports.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
